/* hdl/alvl_pkg.sv */
// alvl_pkg: shared types, constants and the threshold table of the audio level block
// used by alvl_ctrl, alvl_dp and audio_level_dbov_core; no dependencies
`default_nettype none

package alvl_pkg;

	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int FULL_SCALE_SQ   = 65025;
	localparam int LEVEL_W         = 7;
	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 7'd127;
	localparam logic [LEVEL_W-1:0] LEVEL_LAST  = 7'd126;
	localparam logic [3:0] DB_STEP_LAST = 4'd9;

	// thresholds 10^(j/10) with 32 fraction bits
	localparam int TENTH_W   = 36;
	localparam int FRAC_BITS = 32;
	localparam int T_HALF    = 18;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [1:0] MODE_OFF = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_MHI,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic acc;       // accumulate a byte that is not the last
		logic clr;       // last byte: clear accumulators
		logic start;     // last byte: latch sum and count for the level search
		logic mul_lo;
		logic mul_hi;
		logic adv;       // move to the next candidate level
		logic fin_hit;
		logic fin_none;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic sp_zero;
		logic j_zero;
		logic dec_hit;
		logic frac_hit;
		logic k_end;
	} stat_t;

	function automatic logic [TENTH_W-1:0] tenth_decade(input logic [3:0] j);
		logic [TENTH_W-1:0] t;
		case (j)
			4'd1: t = 36'd5407043471;
			4'd2: t = 36'd6807064429;
			4'd3: t = 36'd8569586389;
			4'd4: t = 36'd10788470074;
			4'd5: t = 36'd13581879131;
			4'd6: t = 36'd17098572778;
			4'd7: t = 36'd21525827776;
			4'd8: t = 36'd27099411597;
			4'd9: t = 36'd34116137904;
			default: t = 36'd4294967296;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

/* hdl/alvl_dp.sv */
// alvl_dp: accumulators, level search datapath with shared multiplier, output registers
// depends on alvl_pkg; driven by alvl_ctrl through cmd_t, reports stat_t
`default_nettype none

module alvl_dp #(
	parameter int MAX_SAMPLES = alvl_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire alvl_pkg::cmd_t                    cmd,
	input  wire logic [7:0]                        sample,
	output alvl_pkg::stat_t                        stat,
	output logic [alvl_pkg::LEVEL_W-1:0]           level,
	output logic                                   too_long
);
	import alvl_pkg::*;

	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam longint unsigned SUM_MAX = 64'(MAX_SAMPLES) * 64'(FULL_SCALE_SQ);
	localparam int SW  = $clog2(SUM_MAX + 1);
	localparam int SPW = SW + 4;
	localparam int PW  = SPW + TENTH_W;

	logic [SW-1:0]  sum_q;
	logic [NW-1:0]  cnt_q;
	logic           ovf_q;
	logic [SW-1:0]  sum_nxt;
	logic [NW-1:0]  cnt_nxt;
	logic           ovf_nxt;
	logic           room;

	logic [SPW-1:0] sp_q;
	logic [SW-1:0]  d_q;
	logic [PW-1:0]  prod_q;
	logic [6:0]     k_q;
	logic [3:0]     j_q;
	logic           tl_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [LEVEL_W-1:0] level_q;
	logic           too_long_q;

	logic [TENTH_W-1:0]    t;
	logic [T_HALF-1:0]     t_part;
	logic [SPW+T_HALF-1:0] pp;

	assign room    = cnt_q < NW'(MAX_SAMPLES);
	assign sum_nxt = room ? sum_q + SW'({8'd0, sample} * {8'd0, sample}) : sum_q;
	assign cnt_nxt = room ? cnt_q + NW'(1) : cnt_q;
	assign ovf_nxt = ovf_q | ~room;

	assign t      = tenth_decade(j_q);
	assign t_part = cmd.mul_hi ? t[TENTH_W-1:T_HALF] : t[T_HALF-1:0];
	assign pp     = sp_q * t_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc) begin
			sum_q <= sum_nxt;
			cnt_q <= cnt_nxt;
			ovf_q <= ovf_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			j_q <= '0;
		end else if (cmd.start) begin
			k_q <= '0;
			j_q <= '0;
		end else if (cmd.adv) begin
			k_q <= k_q + 7'd1;
			j_q <= (j_q == DB_STEP_LAST) ? 4'd0 : j_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sp_q <= SPW'(sum_nxt);
			d_q  <= SW'(cnt_nxt * FULL_SCALE_SQ);
			tl_q <= ovf_nxt;
		end else if (cmd.adv && j_q == DB_STEP_LAST) begin
			// next decade: times ten
			sp_q <= (sp_q << 3) + (sp_q << 1);
		end
		if (cmd.mul_lo)
			prod_q <= PW'(pp);
		else if (cmd.mul_hi)
			prod_q <= prod_q + (PW'(pp) << T_HALF);
		if (cmd.fin_hit)
			lvl_q <= k_q;
		else if (cmd.fin_none)
			lvl_q <= LEVEL_FLOOR;
		if (cmd.load_out) begin
			level_q    <= lvl_q;
			too_long_q <= tl_q;
		end
	end

	assign stat.sp_zero  = (sp_q == '0);
	assign stat.j_zero   = (j_q == 4'd0);
	assign stat.dec_hit  = (sp_q >= SPW'(d_q));
	assign stat.frac_hit = (prod_q[PW-1:FRAC_BITS] >= (PW-FRAC_BITS)'(d_q));
	assign stat.k_end    = (k_q == LEVEL_LAST);

	assign level    = level_q;
	assign too_long = too_long_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_SAMPLES))
		else $error("byte count beyond limit");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= LEVEL_LAST)
		else $error("level search ran past last candidate");

endmodule

`default_nettype wire

/* hdl/alvl_ctrl.sv */
// alvl_ctrl: state machine that sequences byte intake, level search and result handoff
// depends on alvl_pkg; drives alvl_dp through cmd_t
`default_nettype none

module alvl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            last,
	input  wire logic            mode_on,
	input  wire logic            out_ready,
	input  wire alvl_pkg::stat_t stat,
	output logic                 in_ready,
	output logic                 out_valid,
	output alvl_pkg::cmd_t       cmd
);
	import alvl_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.acc   = in_fire & ~last;
				cmd.clr   = in_fire & last;
				cmd.start = in_fire & last & mode_on;
				if (cmd.start)
					state_nxt = ST_TEST;
			end
			ST_TEST: begin
				if (stat.sp_zero) begin
					cmd.fin_none = 1'b1;
					state_nxt    = ST_DONE;
				end else if (stat.j_zero) begin
					if (stat.dec_hit) begin
						cmd.fin_hit = 1'b1;
						state_nxt   = ST_DONE;
					end else if (stat.k_end) begin
						cmd.fin_none = 1'b1;
						state_nxt    = ST_DONE;
					end else begin
						cmd.adv = 1'b1;
					end
				end else begin
					cmd.mul_lo = 1'b1;
					state_nxt  = ST_MHI;
				end
			end
			ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_CMP;
			end
			ST_CMP: begin
				if (stat.frac_hit) begin
					cmd.fin_hit = 1'b1;
					state_nxt   = ST_DONE;
				end else if (stat.k_end) begin
					cmd.fin_none = 1'b1;
					state_nxt    = ST_DONE;
				end else begin
					cmd.adv   = 1'b1;
					state_nxt = ST_TEST;
				end
			end
			ST_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending transaction");

	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last && mode_on) |=> (state_q == ST_TEST))
		else $error("level search did not start after last byte");

	a_mode_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last && !mode_on) |=> (state_q == ST_IDLE && !cmd.load_out))
		else $error("result produced with level calculation off");

	a_mul_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_lo |=> cmd.mul_hi)
		else $error("partial product sequence broken");

endmodule

`default_nettype wire

/* hdl/audio_level_dbov_core.sv */
// audio_level_dbov_core: RFC 6464 packet audio level with an APB mode register
// Bytes enter one per cycle while idle; if the mode is not off, a last byte starts a
// search over levels 0..126. A whole-decade candidate is tested in ST_TEST alone, a
// fractional one in ST_TEST, ST_MHI and ST_CMP (shared 32x18 multiplier at the default
// limit, two passes); the result then waits in ST_DONE while a held result blocks; no byte is
// taken meanwhile. Reset clears mode, accumulators, search state and output valid.
`default_nettype none

module audio_level_dbov_core #(
	parameter int MAX_SAMPLES = alvl_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [alvl_pkg::APB_AW-1:0]   paddr,
	input  wire logic [alvl_pkg::APB_DW-1:0]   pwdata,
	output logic [alvl_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    sample,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [alvl_pkg::LEVEL_W-1:0]       level,
	output logic                               too_long
);
	import alvl_pkg::*;

	logic [1:0] mode_q;
	logic       sel_mode;
	cmd_t       cmd;
	stat_t      stat;

	// word index is paddr[2]; only index zero exists
	assign sel_mode = ~paddr[2];
	assign pready   = 1'b1;
	assign prdata   = sel_mode ? {{(APB_DW-2){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_OFF;
		else if (psel && penable && pwrite && sel_mode)
			mode_q <= pwdata[1:0];
	end

	alvl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.mode_on   (mode_q != MODE_OFF),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	alvl_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (sample),
		.stat     (stat),
		.level    (level),
		.too_long (too_long)
	);

endmodule

`default_nettype wire
